>>> hdl/rsio_pkg.sv
// ---------------------------------------------------------------------------
// Reel stepper I/O controller package
// Access codes, output bank selects and the reel index sensor table.
// ---------------------------------------------------------------------------
`default_nettype none

package rsio_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    MODE_PORT1 = 2'd0,
    MODE_BANK  = 2'd1,
    MODE_SENSE = 2'd2,
    MODE_PIN   = 2'd3
  } mode_t;

  // output bank selects, taken from inverted port-1 bits 7:5
  localparam logic [2:0] BANK_SEL_10 = 3'd0;
  localparam logic [2:0] BANK_SEL_20 = 3'd1;
  localparam logic [2:0] BANK_SEL_30 = 3'd2;
  localparam logic [2:0] BANK_SEL_40 = 3'd4;

  // sensor table geometry
  localparam int ROM_SIZE     = 200;
  localparam int ROM_LAST     = 199;
  localparam int SENSOR_REELS = 3;
  localparam int ROW_LEN      = 18;
  localparam int MAX_REELS    = 5;

  localparam logic [7:0] READ_MARK = 8'h40;

  // every table entry is either all sensors on (7) or all off (0),
  // so one bit per entry is kept
  function automatic logic [ROM_SIZE-1:0] build_index_rom();
    logic [ROM_SIZE-1:0] rom;
    int                  k;
    rom = '0;
    k   = 0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (i == 90 || i == 91 || i == 181) begin
        k = 0;
      end
      if (i == 90) begin
        rom[i] = 1'b1;
      end else if (i > 180) begin
        rom[i] = !(k == 2 || k == 11);
        k = k + 1;
      end else begin
        rom[i] = !(k == 2 || k >= 11);
        k = (k == ROW_LEN - 1) ? 0 : k + 1;
      end
    end
    return rom;
  endfunction

  localparam logic [ROM_SIZE-1:0] INDEX_ROM = build_index_rom();

endpackage

`default_nettype wire

>>> hdl/reel_stepper_io_controller.sv
// ---------------------------------------------------------------------------
// Reel stepper I/O controller
// Bus-access device: port-1 latch and reel stepping, four output banks,
// reel index sensor read-back and EEPROM pin drive.
// ---------------------------------------------------------------------------
//  channel  dir  beat fields (low bit first)
//  s_*      in   tuser: mode[1:0]; tdata: data[7:0], sda_in[8]
//  m_*      out  tdata: read_data[7:0], lamp_bank10..40[39:8],
//                eeprom_clock[40], eeprom_data_out[41]
//
//  One beat per cycle sustained while m_tready holds high; m_tvalid rises
//  once the access has passed the input register, then the result register.
//  The access executes when it moves from the input register into the
//  result register, so state only changes when the result slot frees up.
//  A stall on m_tready holds both registers; s_tready drops once the input
//  register is full and cannot drain.
//  Synchronous active-high reset clears all reel positions, banks and pins.
// ---------------------------------------------------------------------------
`default_nettype none

module reel_stepper_io_controller
  import rsio_pkg::*;
#(
  parameter int STEPS_PER_TURN = 200,
  parameter int REEL_COUNT     = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // data[7:0], sda_in[8], zero fill
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // read_data[7:0], lamp_bank10[15:8],
                                      // lamp_bank20[23:16], lamp_bank30[31:24],
                                      // lamp_bank40[39:32], eeprom_clock[40],
                                      // eeprom_data_out[41], zero fill
);

  localparam int POS_W = (STEPS_PER_TURN > 2) ? $clog2(STEPS_PER_TURN) : 1;
  localparam int IDX_W = (POS_W > 8) ? POS_W : 8;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(STEPS_PER_TURN - 1);

  // input register
  logic       in_valid;
  mode_t      in_mode;
  logic [7:0] in_data;
  logic       in_sda;

  // architectural state
  logic [REEL_COUNT-1:0][POS_W-1:0] pos;
  logic [REEL_COUNT-1:0][POS_W-1:0] pos_next;
  logic [7:0] port1_latch, port1_latch_next;
  logic [7:0] bank10, bank10_next;
  logic [7:0] bank20, bank20_next;
  logic [7:0] bank30, bank30_next;
  logic [7:0] bank40, bank40_next;
  logic       sda_dir, sda_dir_next;
  logic [1:0] pin_latch, pin_latch_next;

  // result register
  logic [7:0] read_q, read_next;

  logic advance;
  logic [2:0] bank_sel;
  logic [REEL_COUNT-1:0] sense;
  logic do_step;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign bank_sel = ~port1_latch[7:5];

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= mode_t'(s_tuser);
      in_data <= s_tdata[7:0];
      in_sda  <= s_tdata[8];
    end
  end

  // index sensors from current reel positions
  always_comb begin
    logic [IDX_W-1:0] pw;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < REEL_COUNT; i++) begin
      pw  = IDX_W'(pos[i]);
      idx = IDX_W'(ROM_LAST) - pw;
      sense[i] = 1'b0;
      if (i < SENSOR_REELS && pw < IDX_W'(ROM_SIZE)) begin
        sense[i] = INDEX_ROM[idx[7:0]];
      end
    end
  end

  // access execution
  assign do_step = (in_mode == MODE_PORT1) && (in_data[4:0] != 5'd0) && bank40[0];

  always_comb begin
    pos_next         = pos;
    port1_latch_next = port1_latch;
    bank10_next      = bank10;
    bank20_next      = bank20;
    bank30_next      = bank30;
    bank40_next      = bank40;
    sda_dir_next     = sda_dir;
    pin_latch_next   = pin_latch;
    read_next        = 8'd0;
    case (in_mode)
      MODE_PORT1: begin
        port1_latch_next = in_data;
        for (int i = 0; i < REEL_COUNT; i++) begin
          if (do_step && in_data[i]) begin
            if (bank10[5]) begin
              pos_next[i] = (pos[i] == POS_LAST) ? '0 : pos[i] + POS_W'(1);
            end else begin
              pos_next[i] = (pos[i] == '0) ? POS_LAST : pos[i] - POS_W'(1);
            end
          end
        end
      end
      MODE_BANK: begin
        case (bank_sel)
          BANK_SEL_10: bank10_next = in_data;
          BANK_SEL_20: bank20_next = in_data;
          BANK_SEL_30: bank30_next = in_data;
          BANK_SEL_40: bank40_next = in_data;
          default: ;
        endcase
      end
      MODE_SENSE: begin
        read_next = READ_MARK | 8'(sense);
        read_next[7] = !sda_dir && in_sda;
      end
      MODE_PIN: begin
        sda_dir_next   = in_data[1];
        pin_latch_next = {in_data[2], in_data[0]};
      end
      default: ;
    endcase
  end

  // state and result update
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      port1_latch <= '0;
      bank10      <= '0;
      bank20      <= '0;
      bank30      <= '0;
      bank40      <= '0;
      sda_dir     <= 1'b0;
      pin_latch   <= '0;
    end else if (advance) begin
      pos         <= pos_next;
      port1_latch <= port1_latch_next;
      bank10      <= bank10_next;
      bank20      <= bank20_next;
      bank30      <= bank30_next;
      bank40      <= bank40_next;
      sda_dir     <= sda_dir_next;
      pin_latch   <= pin_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_q <= read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // banks and pins only change when a result is loaded, so they sit
  // directly on the output beat
  assign m_tdata = {6'd0, pin_latch[0], pin_latch[1],
                    bank40, bank30, bank20, bank10, read_q};

  // checks
  logic pos_in_range;
  always_comb begin
    pos_in_range = 1'b1;
    for (int i = 0; i < REEL_COUNT; i++) begin
      if (IDX_W'(pos[i]) > IDX_W'(STEPS_PER_TURN - 1)) begin
        pos_in_range = 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos_in_range)
    else $error("reel position beyond turn");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pos) && $stable(bank10) && $stable(bank40) && $stable(pin_latch))
    else $error("state changed without an access");

  a_no_power: assert property (@(posedge clk) disable iff (rst)
    advance && !bank40[0] |=> $stable(pos))
    else $error("reel stepped with motor power off");

  a_read_mark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (read_q != 8'd0) |-> read_q[6] && !read_q[5])
    else $error("malformed sensor byte");
`endif

endmodule

`default_nettype wire

>>> sim/tb_reel_stepper_io_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Reel stepper I/O controller testbench
// Sends bus accesses through the slave stream and checks every result beat
// against a behavioural model of the reels, output banks, sensors and pins.
// A short directed table comes first, then random reel runs and noise.
// ---------------------------------------------------------------------------

module tb_reel_stepper_io_controller;
  import rsio_pkg::*;

  localparam int TURN_STEPS   = 200;
  localparam int REELS        = 5;
  localparam int TOTAL_ITEMS  = 450;
  localparam int IDLE_PERCENT = 11;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] bank10;
    logic [7:0] bank20;
    logic [7:0] bank30;
    logic [7:0] bank40;
    logic       eeprom_clock;
    logic       eeprom_data_out;
  } reel_result_t;

  // one directed access; read_data is only used where fixed_read is set
  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic       sda_in;
    logic       fixed_read;
    logic [7:0] read_data;
  } access_row_t;

  localparam access_row_t DIRECTED_ROWS [25] = '{
    '{MODE_SENSE, 8'h00, 1'b1, 1'b1, 8'hC7},  // after reset, sda high
    '{MODE_SENSE, 8'hFF, 1'b0, 1'b1, 8'h47},  // after reset, sda low
    '{MODE_PORT1, 8'h1F, 1'b0, 1'b0, 8'h00},  // step request with power off
    '{MODE_BANK,  8'hFF, 1'b0, 1'b0, 8'h00},  // unused bank select
    '{MODE_PORT1, 8'h60, 1'b0, 1'b0, 8'h00},  // select bank40
    '{MODE_BANK,  8'h01, 1'b0, 1'b0, 8'h00},  // motor power on
    '{MODE_PORT1, 8'hE0, 1'b0, 1'b0, 8'h00},  // select bank10
    '{MODE_BANK,  8'h00, 1'b0, 1'b0, 8'h00},  // backward
    '{MODE_PORT1, 8'hFF, 1'b0, 1'b0, 8'h00},  // all reels back through zero
    '{MODE_SENSE, 8'h00, 1'b1, 1'b1, 8'hC7},
    '{MODE_BANK,  8'hFF, 1'b0, 1'b0, 8'h00},  // forward
    '{MODE_PORT1, 8'hE1, 1'b0, 1'b0, 8'h00},  // reel 0 wraps to zero
    '{MODE_SENSE, 8'h00, 1'b0, 1'b1, 8'h47},
    '{MODE_PORT1, 8'hC2, 1'b0, 1'b0, 8'h00},  // select bank20, reel 1 wraps
    '{MODE_BANK,  8'hAA, 1'b0, 1'b0, 8'h00},
    '{MODE_PORT1, 8'hA4, 1'b0, 1'b0, 8'h00},  // select bank30, reel 2 wraps
    '{MODE_BANK,  8'h55, 1'b0, 1'b0, 8'h00},
    '{MODE_PORT1, 8'h9C, 1'b0, 1'b0, 8'h00},  // unused select, reels 2-4 step
    '{MODE_BANK,  8'h33, 1'b0, 1'b0, 8'h00},
    '{MODE_SENSE, 8'hA5, 1'b1, 1'b1, 8'hC7},
    '{MODE_PIN,   8'hFF, 1'b0, 1'b0, 8'h00},  // sda driven, both pins high
    '{MODE_SENSE, 8'h00, 1'b1, 1'b1, 8'h47},  // sda masked while driven
    '{MODE_PIN,   8'h05, 1'b0, 1'b0, 8'h00},
    '{MODE_PIN,   8'h00, 1'b0, 1'b0, 8'h00},
    '{MODE_SENSE, 8'h00, 1'b1, 1'b1, 8'hC7}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // data[7:0], sda_in[8], zero fill
  logic [1:0]  s_tuser  = MODE_PORT1;  // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // read_data, lamp_bank10..40, eeprom_clock, eeprom_data_out

  // model state
  logic [7:0]   sensor_rom [ROM_SIZE];
  logic [7:0]   reel_pos [REELS];
  logic [7:0]   port1_q;
  logic [7:0]   bank10_q;
  logic [7:0]   bank20_q;
  logic [7:0]   bank30_q;
  logic [7:0]   bank40_q;
  logic         sda_dir_q;
  logic [1:0]   pin_q;

  reel_result_t expected_q [$];
  reel_result_t want;
  reel_result_t got;
  int           sent         = 0;
  int           reads_sent   = 0;
  int           steps_taken  = 0;
  int           checked      = 0;
  int           fail_count   = 0;
  int           stall_cycles = 0;
  bit           quiet        = 1'b0;

  reel_stepper_io_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // behavioural model of one bus access
  task automatic predict_access(input mode_t mode, input logic [7:0] data,
                                input logic sda_in, output reel_result_t res);
    logic [2:0] bank_sel;
    logic [7:0] rd;
    rd = '0;
    case (mode)
      MODE_PORT1: begin
        if (data[4:0] != 5'd0 && bank40_q[0]) begin
          for (int i = 0; i < REELS; i++) begin
            if (data[i]) begin
              if (bank10_q[5]) begin
                reel_pos[i] = (reel_pos[i] == TURN_STEPS - 1) ? 8'd0 : reel_pos[i] + 8'd1;
              end else begin
                reel_pos[i] = (reel_pos[i] == 0) ? 8'(TURN_STEPS - 1) : reel_pos[i] - 8'd1;
              end
              steps_taken++;
            end
          end
        end
        port1_q = data;
      end
      MODE_BANK: begin
        bank_sel = ~port1_q[7:5];
        case (bank_sel)
          BANK_SEL_10: bank10_q = data;
          BANK_SEL_20: bank20_q = data;
          BANK_SEL_30: bank30_q = data;
          BANK_SEL_40: bank40_q = data;
          default: ;
        endcase
      end
      MODE_SENSE: begin
        // sensor table is looked up from the far end of the turn
        for (int i = 0; i < REELS; i++) begin
          rd[i] = sensor_rom[ROM_LAST - int'(reel_pos[i])][i];
        end
        rd[7] = sda_in & ~sda_dir_q;
        rd    = rd | READ_MARK;
      end
      MODE_PIN: begin
        sda_dir_q = data[1];
        pin_q     = {data[2], data[0]};
      end
      default: ;
    endcase
    res.read_data       = rd;
    res.bank10          = bank10_q;
    res.bank20          = bank20_q;
    res.bank30          = bank30_q;
    res.bank40          = bank40_q;
    res.eeprom_clock    = pin_q[1];
    res.eeprom_data_out = pin_q[0];
  endtask

  // drive one access and record what it should return once accepted
  task automatic send_access(input mode_t mode, input logic [7:0] data, input logic sda_in,
                             input logic fixed_read, input logic [7:0] fixed_value);
    reel_result_t res;
    quiet = (sent >= 200 && sent < 300);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, sda_in, data};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    predict_access(mode, data, sda_in, res);
    if (fixed_read) res.read_data = fixed_value;
    expected_q.push_back(res);
    sent++;
    if (mode == MODE_SENSE) reads_sent++;
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
        $display("mismatch on beat %0d, %s: expected %02h, got %02h",
                 checked, name, exp_v, act_v);
      end
    end
  endtask

  // result side ready, stalling at random outside the quiet stretch
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected result beat %h", m_tdata);
        end
      end else begin
        want                = expected_q.pop_front();
        got.read_data       = m_tdata[7:0];
        got.bank10          = m_tdata[15:8];
        got.bank20          = m_tdata[23:16];
        got.bank30          = m_tdata[31:24];
        got.bank40          = m_tdata[39:32];
        got.eeprom_clock    = m_tdata[40];
        got.eeprom_data_out = m_tdata[41];
        check_field("read_data", want.read_data, got.read_data);
        check_field("lamp_bank10", want.bank10, got.bank10);
        check_field("lamp_bank20", want.bank20, got.bank20);
        check_field("lamp_bank30", want.bank30, got.bank30);
        check_field("lamp_bank40", want.bank40, got.bank40);
        check_field("eeprom_clock", 8'(want.eeprom_clock), 8'(got.eeprom_clock));
        check_field("eeprom_data_out", 8'(want.eeprom_data_out), 8'(got.eeprom_data_out));
        checked++;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               stall_cycles, expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          k;
    int          run_len;
    int          pick;
    int          n_directed;
    bit          drift;
    bit          paused_mid;
    logic [7:0]  value;

    // index sensor table: five rows of 18, one lone lit entry, five rows,
    // then a 19-entry tail with its own gaps
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (i == 90) begin
        sensor_rom[i] = 8'h07;
      end else if (i >= 181) begin
        k = i - 181;
        sensor_rom[i] = (k == 2 || k == 11) ? 8'h00 : 8'h07;
      end else begin
        k = (i < 90) ? i % 18 : (i - 91) % 18;
        sensor_rom[i] = (k == 2 || k >= 11) ? 8'h00 : 8'h07;
      end
    end

    // model reset state
    for (int i = 0; i < REELS; i++) reel_pos[i] = 8'd0;
    port1_q    = '0;
    bank10_q   = '0;
    bank20_q   = '0;
    bank30_q   = '0;
    bank40_q   = '0;
    sda_dir_q  = 1'b0;
    pin_q      = '0;
    drift      = 1'b1;
    paused_mid = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED_ROWS[n]) begin
      send_access(DIRECTED_ROWS[n].mode, DIRECTED_ROWS[n].data, DIRECTED_ROWS[n].sda_in,
                  DIRECTED_ROWS[n].fixed_read, DIRECTED_ROWS[n].read_data);
    end
    n_directed = sent;
    wait_drained();

    // random part: mostly powered reel runs, the rest noise
    while (sent < TOTAL_ITEMS) begin
      if (!paused_mid && sent >= 320) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // power up through bank40, then set the direction through bank10
        value = 8'h60 | 8'($urandom_range(0, 31));
        send_access(MODE_PORT1, value, 1'($urandom), 1'b0, 8'h00);
        value = 8'($urandom);
        if ($urandom_range(0, 7) != 0) value[0] = 1'b1;
        send_access(MODE_BANK, value, 1'($urandom), 1'b0, 8'h00);
        value = 8'hE0 | 8'($urandom_range(0, 31));
        send_access(MODE_PORT1, value, 1'($urandom), 1'b0, 8'h00);
        if ($urandom_range(0, 7) == 0) drift = ~drift;
        value    = 8'($urandom);
        value[5] = ($urandom_range(0, 4) != 0) ? drift : ~drift;
        send_access(MODE_BANK, value, 1'($urandom), 1'b0, 8'h00);
        run_len = $urandom_range(6, 24);
        repeat (run_len) begin
          pick  = $urandom_range(0, 99);
          value = 8'($urandom);
          if (pick < 55) begin
            send_access(MODE_PORT1, value, 1'($urandom), 1'b0, 8'h00);
          end else if (pick < 90) begin
            send_access(MODE_SENSE, value, 1'($urandom), 1'b0, 8'h00);
          end else if (pick < 96) begin
            send_access(MODE_PIN, value, 1'($urandom), 1'b0, 8'h00);
          end else begin
            send_access(MODE_BANK, value, 1'($urandom), 1'b0, 8'h00);
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_access(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                      1'b0, 8'h00);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bus accesses (%0d from the directed table), %0d sensor reads",
             sent, n_directed, reads_sent);
    $display("reels took %0d single steps; %0d result beats compared, %0d mismatches",
             steps_taken, checked, fail_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
